/* rtl/owbm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owbm_pkg
// Shared types and constants of the 1-Wire bus master.
// ----------------------------------------------------------------------------
package owbm_pkg;

   localparam int TICK_W  = 10;
   localparam int SHORT_W = 4;
   localparam int BIT_W   = 3;
   localparam int BYTE_W  = 8;
   localparam int FUNC_W  = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;

   typedef logic [FUNC_W-1:0]    func_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam func_type CMD_NONE  = 2'd0;
   localparam func_type CMD_RESET = 2'd1;
   localparam func_type CMD_WRITE = 2'd2;
   localparam func_type CMD_READ  = 2'd3;

   localparam csr_idx_type CSR_RESET_LOW   = 3'd0;
   localparam csr_idx_type CSR_PRES_WAIT   = 3'd1;
   localparam csr_idx_type CSR_RESET_RECOV = 3'd2;
   localparam csr_idx_type CSR_SLOT        = 3'd3;
   localparam csr_idx_type CSR_SHORT       = 3'd4;

   localparam logic [TICK_W-1:0]  RESET_LOW_DEF   = 10'd480;
   localparam logic [TICK_W-1:0]  PRES_WAIT_DEF   = 10'd60;
   localparam logic [TICK_W-1:0]  RESET_RECOV_DEF = 10'd480;
   localparam logic [TICK_W-1:0]  SLOT_DEF        = 10'd60;
   localparam logic [SHORT_W-1:0] SHORT_DEF       = 4'd1;

   typedef enum logic [5:0] {
      PH_IDLE    = 6'b000001,
      PH_RST_LOW = 6'b000010,
      PH_RST_REL = 6'b000100,
      PH_RST_REC = 6'b001000,
      PH_SLOT_LO = 6'b010000,
      PH_SLOT_HI = 6'b100000
   } phase_type;

   // zero length acts as one tick
   function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
      return (v == '0) ? TICK_W'(1) : v;
   endfunction

endpackage

/* rtl/owbm_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owbm_req_if / owbm_rsp_if
// Valid/ready channels for bus ticks and their results.
// ----------------------------------------------------------------------------
interface owbm_req_if;
   logic                        valid;
   logic                        ready;
   logic [owbm_pkg::FUNC_W-1:0] func;
   logic [owbm_pkg::BYTE_W-1:0] write_value;
   logic                        line_level;

   modport source (output valid, output func, output write_value, output line_level,
                   input ready);
   modport sink   (input valid, input func, input write_value, input line_level,
                   output ready);
endinterface

interface owbm_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        drive_low;
   logic                        busy_res;
   logic                        done_res;
   logic [owbm_pkg::BYTE_W-1:0] read_value;
   logic                        no_presence;

   modport source (output valid, output drive_low, output busy_res, output done_res,
                   output read_value, output no_presence, input ready);
   modport sink   (input valid, input drive_low, input busy_res, input done_res,
                   input read_value, input no_presence, output ready);
endinterface

/* rtl/onewire_bus_master.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// onewire_bus_master
// 1-Wire bus master: reset/presence, byte write and byte read, one tick per request.
// A single output register holds each result, offered in the cycle after acceptance.
// Throughput: one request per cycle unless rsp stalls; the register refills as it drains.
// Reset: synchronous; phase idle, presence 1, read byte 0, timing registers to defaults.
// ----------------------------------------------------------------------------
module onewire_bus_master (
   input  logic                                clock,
   input  logic                                reset,
   owbm_req_if.sink                            req,
   owbm_rsp_if.source                          rsp,
   input  logic                                csr_we,
   input  logic [owbm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [owbm_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic [owbm_pkg::TICK_W-1:0]  reset_low_ff, pres_wait_ff, reset_recov_ff, slot_ff;
   logic [owbm_pkg::SHORT_W-1:0] short_ff;

   owbm_pkg::phase_type          phase_ff, phase_in;
   logic [owbm_pkg::TICK_W-1:0]  tick_count_ff, tick_count_in;
   logic [owbm_pkg::BIT_W-1:0]   bit_index_ff, bit_index_in;
   logic [owbm_pkg::BYTE_W-1:0]  shift_byte_ff, shift_byte_in;
   logic [owbm_pkg::FUNC_W-1:0]  active_cmd_ff, active_cmd_in;
   logic                         presence_ff, presence_in;
   logic [owbm_pkg::BYTE_W-1:0]  read_hold_ff, read_hold_in;

   logic rsp_valid_ff;
   logic drive_ff, drive_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic accept;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.drive_low   = drive_ff;
   assign rsp.busy_res    = busy_ff;
   assign rsp.done_res    = done_ff;
   assign rsp.read_value  = read_hold_ff;
   assign rsp.no_presence = presence_ff;

   always_comb begin
      owbm_pkg::phase_type          ph;
      logic [owbm_pkg::TICK_W-1:0]  short_len;
      logic [owbm_pkg::TICK_W-1:0]  len;
      logic [owbm_pkg::TICK_W:0]    tick_inc;
      logic                         one_bit;
      logic                         last;

      ph            = phase_ff;
      tick_count_in = tick_count_ff;
      bit_index_in  = bit_index_ff;
      shift_byte_in = shift_byte_ff;
      active_cmd_in = active_cmd_ff;
      presence_in   = presence_ff;
      read_hold_in  = read_hold_ff;
      drive_in      = 1'b0;
      busy_in       = 1'b0;
      done_in       = 1'b0;

      // command start on an idle tick
      if (phase_ff == owbm_pkg::PH_IDLE && req.func != owbm_pkg::CMD_NONE) begin
         active_cmd_in = req.func;
         tick_count_in = '0;
         bit_index_in  = '0;
         if (req.func == owbm_pkg::CMD_RESET) begin
            ph = owbm_pkg::PH_RST_LOW;
         end else begin
            ph = owbm_pkg::PH_SLOT_LO;
            shift_byte_in = (req.func == owbm_pkg::CMD_WRITE) ? req.write_value : '0;
         end
      end

      short_len = {{(owbm_pkg::TICK_W-owbm_pkg::SHORT_W){1'b0}}, short_ff};
      one_bit   = (active_cmd_in == owbm_pkg::CMD_READ) || shift_byte_in[0];

      unique case (ph)
         owbm_pkg::PH_RST_LOW: len = owbm_pkg::at_least_one(reset_low_ff);
         owbm_pkg::PH_RST_REL: len = owbm_pkg::at_least_one(pres_wait_ff);
         owbm_pkg::PH_RST_REC: len = owbm_pkg::at_least_one(reset_recov_ff);
         owbm_pkg::PH_SLOT_LO: len = owbm_pkg::at_least_one(one_bit ? short_len : slot_ff);
         default:              len = owbm_pkg::at_least_one(one_bit ? slot_ff : short_len);
      endcase

      tick_inc = {1'b0, tick_count_in} + 1'b1;
      last     = (tick_inc >= {1'b0, len});
      phase_in = ph;

      if (ph != owbm_pkg::PH_IDLE) begin
         busy_in  = 1'b1;
         drive_in = (ph == owbm_pkg::PH_RST_LOW) || (ph == owbm_pkg::PH_SLOT_LO);

         if (ph == owbm_pkg::PH_RST_REC && tick_count_in == '0) begin
            presence_in = req.line_level;
         end
         if (ph == owbm_pkg::PH_SLOT_HI && tick_count_in == '0 &&
             active_cmd_in == owbm_pkg::CMD_READ) begin
            shift_byte_in = {req.line_level, shift_byte_in[owbm_pkg::BYTE_W-1:1]};
         end

         if (!last) begin
            tick_count_in = tick_inc[owbm_pkg::TICK_W-1:0];
         end else begin
            tick_count_in = '0;
            unique case (ph)
               owbm_pkg::PH_RST_LOW: phase_in = owbm_pkg::PH_RST_REL;
               owbm_pkg::PH_RST_REL: phase_in = owbm_pkg::PH_RST_REC;
               owbm_pkg::PH_RST_REC: begin
                  phase_in = owbm_pkg::PH_IDLE;
                  done_in  = 1'b1;
               end
               owbm_pkg::PH_SLOT_LO: phase_in = owbm_pkg::PH_SLOT_HI;
               default: begin
                  if (bit_index_in == '1) begin
                     phase_in = owbm_pkg::PH_IDLE;
                     done_in  = 1'b1;
                     if (active_cmd_in == owbm_pkg::CMD_READ) begin
                        read_hold_in = shift_byte_in;
                     end
                  end else begin
                     bit_index_in = bit_index_in + 1'b1;
                     if (active_cmd_in == owbm_pkg::CMD_WRITE) begin
                        shift_byte_in = {1'b0, shift_byte_in[owbm_pkg::BYTE_W-1:1]};
                     end
                     phase_in = owbm_pkg::PH_SLOT_LO;
                  end
               end
            endcase
         end
      end
   end

   // timing registers
   always_ff @(posedge clock) begin
      if (reset) begin
         reset_low_ff   <= owbm_pkg::RESET_LOW_DEF;
         pres_wait_ff   <= owbm_pkg::PRES_WAIT_DEF;
         reset_recov_ff <= owbm_pkg::RESET_RECOV_DEF;
         slot_ff        <= owbm_pkg::SLOT_DEF;
         short_ff       <= owbm_pkg::SHORT_DEF;
      end else if (csr_we) begin
         unique case (csr_index)
            owbm_pkg::CSR_RESET_LOW:   reset_low_ff   <= csr_wdata;
            owbm_pkg::CSR_PRES_WAIT:   pres_wait_ff   <= csr_wdata;
            owbm_pkg::CSR_RESET_RECOV: reset_recov_ff <= csr_wdata;
            owbm_pkg::CSR_SLOT:        slot_ff        <= csr_wdata;
            owbm_pkg::CSR_SHORT:       short_ff       <= csr_wdata[owbm_pkg::SHORT_W-1:0];
            default: ;
         endcase
      end
   end

   // bus state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= owbm_pkg::PH_IDLE;
         tick_count_ff <= '0;
         bit_index_ff  <= '0;
         shift_byte_ff <= '0;
         active_cmd_ff <= owbm_pkg::CMD_NONE;
         presence_ff   <= 1'b1;
         read_hold_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
         drive_ff      <= 1'b0;
         busy_ff       <= 1'b0;
         done_ff       <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff      <= phase_in;
            tick_count_ff <= tick_count_in;
            bit_index_ff  <= bit_index_in;
            shift_byte_ff <= shift_byte_in;
            active_cmd_ff <= active_cmd_in;
            presence_ff   <= presence_in;
            read_hold_ff  <= read_hold_in;
            drive_ff      <= drive_in;
            busy_ff       <= busy_in;
            done_ff       <= done_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 1-Wire bus master. Every bus tick is sent as a
// request and predicted in the bench: reset pulse with presence sample, byte
// write and byte read slot timing, busy/done flags and the held read byte and
// presence flag. Directed runs cover default, zero and longest short-pulse
// timing. Random runs mix commands, ignored commands while busy, random line
// levels and random timing, under random request gaps and result back-pressure.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CLOCK_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 4;

   typedef struct packed {
      owbm_pkg::func_type func;
      logic [7:0]         write_value;
      logic               line_level;
   } bus_tick_type;

   typedef struct packed {
      logic       drive_low;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_value;
      logic       no_presence;
   } bus_result_type;

   typedef enum {LINE_LOW, LINE_HIGH, LINE_RANDOM} line_mode_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            csr_we;
   owbm_pkg::csr_idx_type           csr_index;
   logic [owbm_pkg::CSR_DATA_W-1:0] csr_wdata;

   owbm_req_if req();
   owbm_rsp_if rsp();

   onewire_bus_master u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   int gap_pct     = 0;
   int stall_pct   = 0;
   int fail_count  = 0;
   int cycle_count = 0;

   bus_result_type results_due[$];

   // bench copy of the timing registers
   logic [owbm_pkg::TICK_W-1:0]  cfg_reset_low;
   logic [owbm_pkg::TICK_W-1:0]  cfg_pres_wait;
   logic [owbm_pkg::TICK_W-1:0]  cfg_reset_recov;
   logic [owbm_pkg::TICK_W-1:0]  cfg_slot;
   logic [owbm_pkg::SHORT_W-1:0] cfg_short;

   // bench copy of the master state
   owbm_pkg::phase_type bus_phase;
   int                  tick_cnt;
   logic [2:0]          bit_idx;
   logic [7:0]          shift_reg;
   owbm_pkg::func_type  cur_cmd;
   logic                presence;
   logic [7:0]          read_hold;

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CLOCK_LIMIT) begin
         $display("[onewire_bus_master] ERROR");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp.ready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic int min_one(int v);
      return (v == 0) ? 1 : v;
   endfunction

   function automatic int phase_len();
      logic one_bit;
      one_bit = (cur_cmd == owbm_pkg::CMD_READ) || shift_reg[0];
      case (bus_phase)
         owbm_pkg::PH_RST_LOW: return min_one(cfg_reset_low);
         owbm_pkg::PH_RST_REL: return min_one(cfg_pres_wait);
         owbm_pkg::PH_RST_REC: return min_one(cfg_reset_recov);
         owbm_pkg::PH_SLOT_LO: return min_one(one_bit ? cfg_short : cfg_slot);
         default:              return min_one(one_bit ? cfg_slot : cfg_short);
      endcase
   endfunction

   function automatic bus_result_type advance_bus(bus_tick_type t);
      bus_result_type r;
      int             len;
      r = '0;
      if (bus_phase == owbm_pkg::PH_IDLE && t.func != owbm_pkg::CMD_NONE) begin
         cur_cmd  = t.func;
         tick_cnt = 0;
         bit_idx  = '0;
         if (t.func == owbm_pkg::CMD_RESET) begin
            bus_phase = owbm_pkg::PH_RST_LOW;
         end else begin
            bus_phase = owbm_pkg::PH_SLOT_LO;
            shift_reg = (t.func == owbm_pkg::CMD_WRITE) ? t.write_value : 8'h00;
         end
      end
      if (bus_phase != owbm_pkg::PH_IDLE) begin
         len         = phase_len();
         r.busy_res  = 1'b1;
         r.drive_low = (bus_phase == owbm_pkg::PH_RST_LOW) ||
                       (bus_phase == owbm_pkg::PH_SLOT_LO);
         if (bus_phase == owbm_pkg::PH_RST_REC && tick_cnt == 0)
            presence = t.line_level;
         if (bus_phase == owbm_pkg::PH_SLOT_HI && tick_cnt == 0 &&
             cur_cmd == owbm_pkg::CMD_READ)
            shift_reg = {t.line_level, shift_reg[7:1]};
         if (tick_cnt + 1 < len) begin
            tick_cnt++;
         end else begin
            tick_cnt = 0;
            case (bus_phase)
               owbm_pkg::PH_RST_LOW: bus_phase = owbm_pkg::PH_RST_REL;
               owbm_pkg::PH_RST_REL: bus_phase = owbm_pkg::PH_RST_REC;
               owbm_pkg::PH_RST_REC: begin
                  bus_phase  = owbm_pkg::PH_IDLE;
                  r.done_res = 1'b1;
               end
               owbm_pkg::PH_SLOT_LO: bus_phase = owbm_pkg::PH_SLOT_HI;
               default: begin
                  if (bit_idx == 3'd7) begin
                     bus_phase  = owbm_pkg::PH_IDLE;
                     r.done_res = 1'b1;
                     if (cur_cmd == owbm_pkg::CMD_READ)
                        read_hold = shift_reg;
                  end else begin
                     bit_idx++;
                     if (cur_cmd == owbm_pkg::CMD_WRITE)
                        shift_reg = shift_reg >> 1;
                     bus_phase = owbm_pkg::PH_SLOT_LO;
                  end
               end
            endcase
         end
      end
      r.read_value  = read_hold;
      r.no_presence = presence;
      return r;
   endfunction

   task automatic reset_bus_model();
      cfg_reset_low   = owbm_pkg::RESET_LOW_DEF;
      cfg_pres_wait   = owbm_pkg::PRES_WAIT_DEF;
      cfg_reset_recov = owbm_pkg::RESET_RECOV_DEF;
      cfg_slot        = owbm_pkg::SLOT_DEF;
      cfg_short       = owbm_pkg::SHORT_DEF;
      bus_phase       = owbm_pkg::PH_IDLE;
      tick_cnt        = 0;
      bit_idx         = '0;
      shift_reg       = '0;
      cur_cmd         = owbm_pkg::CMD_NONE;
      presence        = 1'b1;
      read_hold       = '0;
   endtask

   function automatic void check_field(string field, int want, int got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      bus_result_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (results_due.size() == 0) begin
            $error("result with no request outstanding");
            fail_count++;
         end else begin
            want = results_due.pop_front();
            check_field("drive_low", want.drive_low, rsp.drive_low);
            check_field("busy_res", want.busy_res, rsp.busy_res);
            check_field("done_res", want.done_res, rsp.done_res);
            check_field("read_value", want.read_value, rsp.read_value);
            check_field("no_presence", want.no_presence, rsp.no_presence);
         end
      end
   end

   function automatic logic pick_line(line_mode_type mode);
      case (mode)
         LINE_LOW:  return 1'b0;
         LINE_HIGH: return 1'b1;
         default:   return 1'($urandom_range(1));
      endcase
   endfunction

   task automatic send_tick(owbm_pkg::func_type f, logic [7:0] w, logic line);
      bus_tick_type t;
      t = '{func: f, write_value: w, line_level: line};
      @(negedge clock);
      while ($urandom_range(99) < gap_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid       <= 1'b1;
      req.func        <= f;
      req.write_value <= w;
      req.line_level  <= line;
      do @(posedge clock); while (!req.ready);
      results_due.push_back(advance_bus(t));
   endtask

   // commands sent while busy are ignored by the master
   task automatic finish_command(line_mode_type mode);
      while (bus_phase != owbm_pkg::PH_IDLE)
         send_tick(owbm_pkg::func_type'($urandom_range(3)), 8'($urandom), pick_line(mode));
   endtask

   task automatic run_command(owbm_pkg::func_type f, logic [7:0] w, line_mode_type mode);
      send_tick(f, w, pick_line(mode));
      finish_command(mode);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req.valid <= 1'b0;
      while (results_due.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_config(int low_t, int pres_t, int recov_t, int slot_t, int short_t);
      logic [owbm_pkg::CSR_DATA_W-1:0] v[5];
      v[owbm_pkg::CSR_RESET_LOW]   = owbm_pkg::CSR_DATA_W'(low_t);
      v[owbm_pkg::CSR_PRES_WAIT]   = owbm_pkg::CSR_DATA_W'(pres_t);
      v[owbm_pkg::CSR_RESET_RECOV] = owbm_pkg::CSR_DATA_W'(recov_t);
      v[owbm_pkg::CSR_SLOT]        = owbm_pkg::CSR_DATA_W'(slot_t);
      v[owbm_pkg::CSR_SHORT]       = owbm_pkg::CSR_DATA_W'(short_t);
      drain_results();
      for (int i = 0; i < 5; i++) begin
         csr_we    <= 1'b1;
         csr_index <= owbm_pkg::csr_idx_type'(i);
         csr_wdata <= v[i];
         @(negedge clock);
      end
      csr_we <= 1'b0;
      cfg_reset_low   = v[owbm_pkg::CSR_RESET_LOW];
      cfg_pres_wait   = v[owbm_pkg::CSR_PRES_WAIT];
      cfg_reset_recov = v[owbm_pkg::CSR_RESET_RECOV];
      cfg_slot        = v[owbm_pkg::CSR_SLOT];
      cfg_short       = v[owbm_pkg::CSR_SHORT][owbm_pkg::SHORT_W-1:0];
   endtask

   task automatic test_default_timing();
      send_tick(owbm_pkg::CMD_NONE, 8'hFF, 1'b1);
      run_command(owbm_pkg::CMD_WRITE, 8'hA5, LINE_RANDOM);
      send_tick(owbm_pkg::CMD_NONE, 8'h00, 1'b0);
   endtask

   // a zero length acts as one tick
   task automatic test_zero_timing();
      write_config(0, 0, 0, 0, 0);
      send_tick(owbm_pkg::CMD_NONE, 8'h00, 1'b0);
      run_command(owbm_pkg::CMD_RESET, 8'h00, LINE_HIGH);
      run_command(owbm_pkg::CMD_WRITE, 8'h00, LINE_RANDOM);
      run_command(owbm_pkg::CMD_WRITE, 8'hFF, LINE_RANDOM);
      run_command(owbm_pkg::CMD_READ, 8'hFF, LINE_LOW);
      run_command(owbm_pkg::CMD_READ, 8'h00, LINE_HIGH);
      run_command(owbm_pkg::CMD_RESET, 8'h00, LINE_LOW);
      send_tick(owbm_pkg::CMD_NONE, 8'h00, 1'b1);
   endtask

   task automatic test_max_short_pulse();
      write_config(3, 2, 4, 8, 15);
      run_command(owbm_pkg::CMD_RESET, 8'h00, LINE_LOW);
      run_command(owbm_pkg::CMD_WRITE, 8'h3C, LINE_RANDOM);
      run_command(owbm_pkg::CMD_READ, 8'h00, LINE_RANDOM);
   endtask

   function automatic int random_len();
      return ($urandom_range(9) == 0) ? $urandom_range(100) : $urandom_range(6);
   endfunction

   task automatic test_random_traffic();
      int                 gaps[4]   = '{0, 62, 0, 13};
      int                 stalls[4] = '{0, 0, 62, 13};
      owbm_pkg::func_type f;
      for (int m = 0; m < 4; m++) begin
         repeat (2) begin
            write_config(random_len(), random_len(), random_len(), random_len(),
                         $urandom_range(1023));
            gap_pct   = gaps[m];
            stall_pct = stalls[m];
            repeat (36) begin
               if (bus_phase == owbm_pkg::PH_IDLE && $urandom_range(3) == 0)
                  f = owbm_pkg::CMD_NONE;
               else if (bus_phase == owbm_pkg::PH_IDLE)
                  f = owbm_pkg::func_type'($urandom_range(1, 3));
               else
                  f = owbm_pkg::func_type'($urandom_range(3));
               send_tick(f, 8'($urandom), 1'($urandom_range(1)));
            end
            finish_command(LINE_RANDOM);
         end
      end
      gap_pct   = 0;
      stall_pct = 0;
   endtask

   initial begin
      req.valid       = 1'b0;
      req.func        = owbm_pkg::CMD_NONE;
      req.write_value = '0;
      req.line_level  = 1'b1;
      csr_we          = 1'b0;
      csr_index       = owbm_pkg::CSR_RESET_LOW;
      csr_wdata       = '0;
      reset_bus_model();
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      test_default_timing();
      test_zero_timing();
      test_max_short_pulse();
      test_random_traffic();

      drain_results();
      if (fail_count == 0) begin
         $display("[onewire_bus_master] OK");
      end else begin
         $display("[onewire_bus_master] ERROR");
      end
      $finish;
   end

endmodule

/* onewire_bus_master.f */
rtl/owbm_pkg.sv
rtl/owbm_if.sv
rtl/onewire_bus_master.sv
bench/testbench.sv
